@@ rtl/core/sample_voice_mixer_assert.svh @@
// assertion macros for the sample voice mixer
// each macro expects clk and arst_n in the scope where it is used
`ifndef SAMPLE_VOICE_MIXER_ASSERT_SVH
`define SAMPLE_VOICE_MIXER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SVM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SVM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SVM_ASSERT_IMP(lbl, ante, cons, msg)
`define SVM_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/core/svm_pkg.sv @@
package svm_pkg;

	// sample word width, Q1.15
	localparam int SAMPLE_W = 16;

	// width of the shared adder operands
	localparam int ALU_W = 19;

	// command codes
	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_STOP  = 2'd2,
		CMD_TICK  = 2'd3
	} svm_cmd_t;

	// one command item
	typedef struct packed {
		svm_cmd_t             command;
		logic [15:0]          address;
		logic signed [15:0]   sample_value;
		logic [16:0]          length;
		logic [1:0]           channels;
		logic                 loop_flag;
		logic [7:0]           tag;
	} svm_in_t;

	// one result item
	typedef struct packed {
		logic signed [15:0]   left_sample;
		logic signed [15:0]   right_sample;
		logic                 status;
		logic [4:0]           active_voices;
	} svm_out_t;

	// one voice table entry
	typedef struct packed {
		logic [15:0]          base_addr;
		logic [16:0]          length;
		logic [16:0]          index;
		logic                 stereo;
		logic                 loop;
		logic [7:0]           tag;
	} svm_voice_t;

endpackage

@@ rtl/core/sample_voice_mixer.sv @@
// Stereo mixer of sample-playback voices.
// Command channel: an item is taken at a rising edge with start high and busy low.
// Commands: load one sample word into sample memory, start a voice (appended to
// the voice table, status 1 if the table is full), stop all voices of a tag, and
// tick, which mixes one stereo frame from all voices still playing, in table order.
// Result channel: done is high for exactly one cycle with the result; the
// receiver takes it in that cycle and cannot hold it off. busy rises at the
// accepting edge and falls at the edge that shows the result, so one item is in work.
// Sample addresses are reduced modulo SAMPLE_WORDS by restoring steps, none
// when SAMPLE_WORDS is a power of two or at least 131072. A tick drops each
// voice that has reached its length, mixes one sample of a mono voice into both
// sides and two of a stereo voice, and wraps the index of a looping voice.
// The single shared adder does address sums, saturating mixes, index advance
// and loop wrap one operation a cycle; the voice table and the sample memory
// have registered reads.
// Reset empties the voice table; sample memory holds garbage until loaded.
module sample_voice_mixer
	import svm_pkg::*;
#(
	parameter int SAMPLE_WORDS = 65536,
	parameter int MAX_VOICES   = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  svm_in_t  request,
	output logic     busy,
	output logic     done,
	output svm_out_t result
);

`include "sample_voice_mixer_assert.svh"

	localparam int AW          = $clog2(SAMPLE_WORDS);
	localparam int CW          = $clog2(MAX_VOICES + 1);
	localparam int VW          = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int ADDR_SPAN   = 131072;
	localparam bit POW2        = (SAMPLE_WORDS & (SAMPLE_WORDS - 1)) == 0;
	localparam int RED_STEPS   = (SAMPLE_WORDS >= ADDR_SPAN) ? 0 :
		$clog2((ADDR_SPAN + SAMPLE_WORDS - 1) / SAMPLE_WORDS);
	localparam bit NEED_RED    = !POW2 && (RED_STEPS > 0);
	localparam int RED_STEPS_C = (RED_STEPS > 0) ? RED_STEPS : 1;
	localparam int RKW         = (RED_STEPS_C > 1) ? $clog2(RED_STEPS_C) : 1;
	localparam logic [17:0] SW_L = 18'(SAMPLE_WORDS);
	localparam logic signed [ALU_W:0] SAT_HI = 32767;
	localparam logic signed [ALU_W:0] SAT_LO = -32768;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RED,
		S_LOAD_WR,
		S_START,
		S_VSTART,
		S_STOP_CHK,
		S_T_CHK,
		S_T_ADDR,
		S_T_MRD,
		S_T_ACC,
		S_T_MONO_R,
		S_T_ADV,
		S_T_WRAP1,
		S_T_WRAP2,
		S_T_WB
	} state_t;

	state_t                   state_q;
	svm_in_t                  item_q;
	svm_voice_t               voice_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            rd_q;
	logic [CW-1:0]            wr_q;
	logic [16:0]              red_q;
	logic [RKW-1:0]           red_k_q;
	logic                     red_load_q;
	logic                     half_q;
	logic signed [15:0]       left_q;
	logic signed [15:0]       right_q;
	logic                     done_q;
	svm_out_t                 result_q;

	logic signed [ALU_W-1:0]  alu_a;
	logic signed [ALU_W-1:0]  alu_b;
	logic                     alu_cin;
	logic signed [ALU_W:0]    alu_sum;
	logic                     alu_neg;
	logic signed [15:0]       sat_val;
	logic [17:0]              red_div;

	svm_voice_t               vt_mem [MAX_VOICES];
	svm_voice_t               vt_rdata;
	svm_voice_t               vt_wdata;
	logic                     vt_we;
	logic [VW-1:0]            vt_waddr;

	logic                     ram_we;
	logic [SAMPLE_W-1:0]      ram_rdata;
	logic signed [15:0]       mem_rdata;

	function automatic logic signed [15:0] sat16(input logic signed [ALU_W:0] s);
		logic signed [15:0] r;
		if (s > SAT_HI) begin
			r = 16'sh7fff;
		end else if (s < SAT_LO) begin
			r = 16'sh8000;
		end else begin
			r = s[15:0];
		end
		return r;
	endfunction

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// sample memory
	assign ram_we    = (state_q == S_LOAD_WR);
	assign mem_rdata = $signed(ram_rdata);

	svm_sample_ram #(
		.WORDS (SAMPLE_WORDS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (AW'(red_q)),
		.wdata (item_q.sample_value),
		.rdata (ram_rdata)
	);

	// reduction divisor for the current step
	assign red_div = SW_L << red_k_q;

	// shared adder operand select
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_cin = 1'b0;
		case (state_q)
			S_RED: begin
				alu_a = signed'({2'b0, red_q});
				alu_b = -signed'({1'b0, red_div});
			end
			S_T_CHK: begin
				alu_a = signed'({2'b0, vt_rdata.index});
				alu_b = -signed'({2'b0, vt_rdata.length});
			end
			S_T_ADDR: begin
				alu_a   = signed'({3'b0, voice_q.base_addr});
				alu_b   = signed'({2'b0, voice_q.index});
				alu_cin = half_q;
			end
			S_T_ACC: begin
				alu_a = half_q ? ALU_W'(right_q) : ALU_W'(left_q);
				alu_b = ALU_W'(mem_rdata);
			end
			S_T_MONO_R: begin
				alu_a = ALU_W'(right_q);
				alu_b = ALU_W'(mem_rdata);
			end
			S_T_ADV: begin
				alu_a = signed'({2'b0, voice_q.index});
				alu_b = voice_q.stereo ? 19'sd2 : 19'sd1;
			end
			S_T_WRAP1, S_T_WRAP2: begin
				alu_a = signed'({2'b0, voice_q.index});
				alu_b = -signed'({2'b0, voice_q.length});
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	assign alu_sum = (ALU_W+1)'(alu_a) + (ALU_W+1)'(alu_b) + signed'({{ALU_W{1'b0}}, alu_cin});
	assign alu_neg = alu_sum[ALU_W];
	assign sat_val = sat16(alu_sum);

	// voice table write port
	always_comb begin
		vt_we    = 1'b0;
		vt_waddr = wr_q[VW-1:0];
		vt_wdata = voice_q;
		case (state_q)
			S_START: begin
				vt_we              = (count_q != CW'(MAX_VOICES));
				vt_waddr           = count_q[VW-1:0];
				vt_wdata.base_addr = item_q.address;
				vt_wdata.length    = item_q.length;
				vt_wdata.index     = '0;
				vt_wdata.stereo    = item_q.channels[1];
				vt_wdata.loop      = item_q.loop_flag;
				vt_wdata.tag       = item_q.tag;
			end
			S_STOP_CHK: begin
				vt_we    = (vt_rdata.tag != item_q.tag);
				vt_wdata = vt_rdata;
			end
			S_T_WB: begin
				vt_we = 1'b1;
			end
			default: begin
				vt_we = 1'b0;
			end
		endcase
	end

	// voice table memory, registered read at the walk pointer
	always_ff @(posedge clk) begin
		if (vt_we) begin
			vt_mem[vt_waddr] <= vt_wdata;
		end
		vt_rdata <= vt_mem[rd_q[VW-1:0]];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			item_q     <= '0;
			voice_q    <= '0;
			count_q    <= '0;
			rd_q       <= '0;
			wr_q       <= '0;
			red_q      <= '0;
			red_k_q    <= '0;
			red_load_q <= 1'b0;
			half_q     <= 1'b0;
			left_q     <= '0;
			right_q    <= '0;
			done_q     <= 1'b0;
			result_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						item_q     <= request;
						left_q     <= '0;
						right_q    <= '0;
						rd_q       <= '0;
						wr_q       <= '0;
						red_q      <= {1'b0, request.address};
						red_k_q    <= RKW'(RED_STEPS_C - 1);
						red_load_q <= 1'b1;
						case (request.command)
							CMD_LOAD:  state_q <= NEED_RED ? S_RED : S_LOAD_WR;
							CMD_START: state_q <= S_START;
							default:   state_q <= S_VSTART;
						endcase
					end
				end
				// restoring reduction modulo memory size, one step a cycle
				S_RED: begin
					if (!alu_neg) begin
						red_q <= alu_sum[16:0];
					end
					if (red_k_q == '0) begin
						state_q <= red_load_q ? S_LOAD_WR : S_T_MRD;
					end else begin
						red_k_q <= red_k_q - 1'b1;
					end
				end
				S_LOAD_WR: begin
					done_q                 <= 1'b1;
					result_q.left_sample   <= '0;
					result_q.right_sample  <= '0;
					result_q.status        <= 1'b0;
					result_q.active_voices <= 5'(count_q);
					state_q                <= S_IDLE;
				end
				S_START: begin
					done_q                <= 1'b1;
					result_q.left_sample  <= '0;
					result_q.right_sample <= '0;
					if (count_q == CW'(MAX_VOICES)) begin
						result_q.status        <= 1'b1;
						result_q.active_voices <= 5'(count_q);
					end else begin
						count_q                <= count_q + 1'b1;
						result_q.status        <= 1'b0;
						result_q.active_voices <= 5'(count_q + 1'b1);
					end
					state_q <= S_IDLE;
				end
				// next voice of a walk, or the end of it
				S_VSTART: begin
					if (rd_q == count_q) begin
						count_q                <= wr_q;
						done_q                 <= 1'b1;
						result_q.left_sample   <= left_q;
						result_q.right_sample  <= right_q;
						result_q.status        <= 1'b0;
						result_q.active_voices <= 5'(wr_q);
						state_q                <= S_IDLE;
					end else if (item_q.command == CMD_STOP) begin
						state_q <= S_STOP_CHK;
					end else begin
						state_q <= S_T_CHK;
					end
				end
				// keep voices of other tags, compacted in order
				S_STOP_CHK: begin
					if (vt_rdata.tag != item_q.tag) begin
						wr_q <= wr_q + 1'b1;
					end
					rd_q    <= rd_q + 1'b1;
					state_q <= S_VSTART;
				end
				// drop a voice that reached its length
				S_T_CHK: begin
					voice_q <= vt_rdata;
					half_q  <= 1'b0;
					if (!alu_neg) begin
						rd_q    <= rd_q + 1'b1;
						state_q <= S_VSTART;
					end else begin
						state_q <= S_T_ADDR;
					end
				end
				S_T_ADDR: begin
					red_q      <= alu_sum[16:0];
					red_k_q    <= RKW'(RED_STEPS_C - 1);
					red_load_q <= 1'b0;
					state_q    <= NEED_RED ? S_RED : S_T_MRD;
				end
				S_T_MRD: begin
					state_q <= S_T_ACC;
				end
				// saturating mix of the sample just read
				S_T_ACC: begin
					if (!half_q) begin
						left_q <= sat_val;
						if (voice_q.stereo) begin
							half_q  <= 1'b1;
							state_q <= S_T_ADDR;
						end else begin
							state_q <= S_T_MONO_R;
						end
					end else begin
						right_q <= sat_val;
						state_q <= S_T_ADV;
					end
				end
				S_T_MONO_R: begin
					right_q <= sat_val;
					state_q <= S_T_ADV;
				end
				S_T_ADV: begin
					voice_q.index <= alu_sum[16:0];
					state_q       <= voice_q.loop ? S_T_WRAP1 : S_T_WB;
				end
				// loop wrap, at most two subtractions of the length
				S_T_WRAP1: begin
					if (!alu_neg) begin
						voice_q.index <= alu_sum[16:0];
					end
					state_q <= S_T_WRAP2;
				end
				S_T_WRAP2: begin
					if (!alu_neg) begin
						voice_q.index <= alu_sum[16:0];
					end
					state_q <= S_T_WB;
				end
				S_T_WB: begin
					wr_q    <= wr_q + 1'b1;
					rd_q    <= rd_q + 1'b1;
					state_q <= S_VSTART;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`SVM_ASSERT_IMP(a_count_range, 1'b1, count_q <= CW'(MAX_VOICES), "voice count above table size")
	`SVM_ASSERT_IMP(a_compact_order, state_q == S_STOP_CHK || state_q == S_T_WB, wr_q <= rd_q, "write pointer ahead of read pointer")
	`SVM_ASSERT_NXT(a_done_single, done_q, !done_q, "two results in a row")
	`SVM_ASSERT_NXT(a_accept_busy, start && !busy, busy && !done_q, "accepted item not in work")
	`SVM_ASSERT_IMP(a_addr_reduced, state_q == S_T_MRD || state_q == S_LOAD_WR, !NEED_RED || (32'(red_q) < SAMPLE_WORDS), "sample address not reduced")

endmodule

@@ rtl/core/svm_sample_ram.sv @@
module svm_sample_ram
	import svm_pkg::*;
#(
	parameter int WORDS = 65536,
	parameter int AW    = 16
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       addr,
	input  logic [SAMPLE_W-1:0] wdata,
	output logic [SAMPLE_W-1:0] rdata
);

	logic [SAMPLE_W-1:0] mem [WORDS];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
